// File: design/fde_pkg.sv
package fde_pkg;

  localparam int SAMPLE_W = 16;
  localparam int DEPTH    = 32768;
  localparam int ADDR_W   = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CFG_W    = 15;
  localparam int GAIN_W   = 15;
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = SAMPLE_W + GAIN_W + 1;
  localparam int SUM_W    = SAMPLE_W + 2;
  localparam int REG_N    = 2;
  localparam int IDX_W    = $clog2(REG_N);

  localparam logic [IDX_W-1:0] REG_DELAY = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_GAIN  = IDX_W'(1);

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(DEPTH);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    logic  clear;
    addr_t start;
    logic  write;
  } fill_ctl_t;

  function automatic addr_t advance(input addr_t p);
    addr_t r;
    if (p == ADDR_LAST) begin
      r = '0;
    end else begin
      r = p + addr_t'(1);
    end
    return r;
  endfunction

  function automatic sample_t sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    sample_t r;
    hi = SUM_W'((2 ** (SAMPLE_W - 1)) - 1);
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      r = sample_t'(hi);
    end else if (v < lo) begin
      r = sample_t'(lo);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

endpackage

// File: design/fde_ram.sv
module fde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/fde_fill.sv
module fde_fill (
  input  logic              clk,
  input  logic              rst,
  input  fde_pkg::fill_ctl_t ctl,
  input  fde_pkg::addr_t    addr_a,
  input  fde_pkg::addr_t    addr_b,
  output logic              valid_a,
  output logic              valid_b
);

  import fde_pkg::*;

  addr_t            start;
  logic [CNT_W-1:0] count;

  // entries written since the last clear form one run starting at start
  function automatic logic in_run(input addr_t e, input addr_t s, input logic [CNT_W-1:0] n);
    logic [ADDR_W:0] diff;
    logic [ADDR_W:0] span;
    diff = {1'b0, e} - {1'b0, s};
    if (diff[ADDR_W]) begin
      span = diff + (ADDR_W + 1)'(DEPTH);
    end else begin
      span = diff;
    end
    return CNT_W'(span) < n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      start <= advance('0);
      count <= '0;
    end else if (ctl.clear) begin
      start <= ctl.start;
      count <= '0;
    end else if (ctl.write && count != CNT_FULL) begin
      count <= count + CNT_W'(1);
    end
  end

  assign valid_a = in_run(addr_a, start, count);
  assign valid_b = in_run(addr_b, start, count);

endmodule

// File: design/feedback_delay_echo_core.sv
// channel  dir  handshake         payload
// s        in   s_tvalid/tready   s_tdata: in_sample, s_tuser: clear_store
// m        out  m_tvalid/tready   m_tdata: out_sample
// cfg      in   cfg_we            cfg_index, cfg_data (delay_samples, feedback_gain)
// an item steps through old entry read, feedback multiply, write back, output;
// the single delay ram port pair sets this; the next item is taken once the
// result sits in the output register, while that result waits downstream
// a clear needs no sweep: a fill tracker marks entries written since the clear
// reset is synchronous; the store reads as zero right after reset
module feedback_delay_echo_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fde_pkg::SAMPLE_W-1:0]  s_tdata,   // in_sample
  input  logic                          s_tuser,   // clear_store
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fde_pkg::SAMPLE_W-1:0]  m_tdata,   // out_sample
  input  logic                          cfg_we,
  input  logic [fde_pkg::IDX_W-1:0]     cfg_index,
  input  logic [fde_pkg::CFG_W-1:0]     cfg_data
);

  import fde_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_WR   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state;

  logic [CFG_W-1:0]  delay_samples;
  logic [GAIN_W-1:0] feedback_gain;

  addr_t            write_pointer;
  addr_t            read_pointer;
  addr_t            old_addr;
  logic [CFG_W-1:0] wait_count;

  sample_t                  x_q;
  logic signed [PROD_W-1:0] prod_q;
  sample_t                  dly_q;

  logic             s_accept;
  logic             out_load;
  logic             ram_we;
  logic             ram_re;
  addr_t            ram_raddr;
  logic [SAMPLE_W-1:0] ram_rdata;
  fill_ctl_t        fill_ctl;
  logic             valid_a;
  logic             valid_b;

  sample_t                  old_val;
  logic signed [PROD_W-1:0] prod_rnd;
  logic signed [SUM_W-1:0]  fb_sum;
  sample_t                  wval;
  logic signed [SUM_W-1:0]  out_sum;
  logic                     waiting;

  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_load = (state == ST_OUT) && (!m_tvalid || m_tready);
  assign waiting  = wait_count < delay_samples;

  assign ram_we    = (state == ST_WR);
  assign ram_re    = s_accept || (state == ST_MUL);
  assign ram_raddr = (state == ST_IDLE) ? write_pointer : read_pointer;

  assign fill_ctl.clear = s_accept && s_tuser;
  assign fill_ctl.start = advance(write_pointer);
  assign fill_ctl.write = ram_we;

  assign old_val  = valid_a ? sample_t'(ram_rdata) : '0;
  assign prod_rnd = (prod_q + PROD_W'(2 ** (FRAC_W - 1))) >>> FRAC_W;
  assign fb_sum   = SUM_W'(x_q) + SUM_W'(prod_rnd);
  assign wval     = sat(fb_sum);
  assign out_sum  = SUM_W'(x_q) + SUM_W'(dly_q);

  fde_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(write_pointer),
    .wdata(wval),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  fde_fill u_fill (
    .clk    (clk),
    .rst    (rst),
    .ctl    (fill_ctl),
    .addr_a (old_addr),
    .addr_b (read_pointer),
    .valid_a(valid_a),
    .valid_b(valid_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_samples <= '0;
      feedback_gain <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DELAY: delay_samples <= cfg_data;
        REG_GAIN:  feedback_gain <= GAIN_W'(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      write_pointer <= '0;
      read_pointer  <= '0;
      wait_count    <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && !out_load) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_accept) begin
            write_pointer <= advance(write_pointer);
            state         <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_WR;
        end
        ST_WR: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            m_tvalid <= 1'b1;
            if (waiting) begin
              wait_count <= wait_count + CFG_W'(1);
            end else begin
              read_pointer <= advance(read_pointer);
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      x_q      <= sample_t'(s_tdata);
      old_addr <= write_pointer;
    end
    if (state == ST_MUL) begin
      prod_q <= PROD_W'(old_val) * PROD_W'($signed({1'b0, feedback_gain}));
    end
    if (state == ST_WR) begin
      // the fresh entry wins when both pointers meet
      if (read_pointer == write_pointer) begin
        dly_q <= wval;
      end else if (valid_b) begin
        dly_q <= sample_t'(ram_rdata);
      end else begin
        dly_q <= '0;
      end
    end
    if (out_load) begin
      m_tdata <= waiting ? x_q : sat(out_sum);
    end
  end

endmodule
